// ----- design/sliding_time_window_event_buffer_assert.svh -----
// Assertion helpers used by the buffer's walk module. Each use expects i_clk and
// i_rst_n to be visible in the module that expands it.
`ifndef SLIDING_TIME_WINDOW_EVENT_BUFFER_ASSERT_SVH
`define SLIDING_TIME_WINDOW_EVENT_BUFFER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define STWEB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define STWEB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define STWEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/stweb_pkg.sv -----
package stweb_pkg;

    // Number of event slots in the ring. The result fields are sized for 16.
    localparam int CAPACITY = 16;

    // Operation codes on the mode input. Code 3 is unused.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_EXPIRE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ADD_DONE    = 2'd0;
    localparam logic [1:0] KIND_EXPIRE_DONE = 2'd1;
    localparam logic [1:0] KIND_QUERY_MATCH = 2'd2;
    localparam logic [1:0] KIND_QUERY_DONE  = 2'd3;

    // Configuration register map: the index is byte address bit 2.
    localparam int         PADDR_W         = 3;
    localparam logic       REG_WINDOW_SPAN = 1'b0;
    localparam logic [31:0] WINDOW_SPAN_RESET = 32'd60;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [31:0] ev_type;
        logic [7:0]  ev_ifid;
        logic [31:0] ev_tag;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  number;
        logic        dropped_oldest;
        logic [3:0]  slot;
        logic [31:0] match_time;
        logic [31:0] match_type;
        logic [7:0]  match_interface_id;
        logic [31:0] match_tag;
        logic [4:0]  occupancy;
        logic        last;
    } t_result;

endpackage

// ----- design/sliding_time_window_event_buffer.sv -----
// Sliding time-window event buffer: a ring of 16 event slots kept in
// arrival order in one memory with a registered read port. An add writes the
// tail and its result appears on the next cycle; when the ring is full the
// oldest entry is overwritten and dropped_oldest is set. An expire checks the
// head entry once per cycle, and an entry expires only while it is strictly
// older than time_value - window_span. A query reads one entry per cycle from
// the oldest on while no match waits on a stalled output; each match, up to
// max_found, is one result and a final query done result carries the count.
// The single memory read per cycle sets the walk rate. An unused mode code is
// taken and ignored. window_span is register 0 at byte address 0 of the APB
// port and may be changed only while the block is idle.
module sliding_time_window_event_buffer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [stweb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_time_value,
    input  logic [31:0] i_evt_type,
    input  logic [7:0]  i_interface_id,
    input  logic        i_match_interface,
    input  logic [31:0] i_event_tag,
    input  logic [4:0]  i_max_found,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_number,
    output logic        o_dropped_oldest,
    output logic [3:0]  o_slot,
    output logic [31:0] o_match_time,
    output logic [31:0] o_match_type,
    output logic [7:0]  o_match_interface_id,
    output logic [31:0] o_match_tag,
    output logic [4:0]  o_occupancy,
    output logic        o_last
);

    localparam int AW = $clog2(stweb_pkg::CAPACITY);

    logic [31:0]        r_window_span;
    logic               w_span_sel;

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    stweb_pkg::t_entry  w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;
    stweb_pkg::t_entry  w_mem_rdata;
    stweb_pkg::t_result w_result;

    assign pready     = 1'b1;
    assign w_span_sel = (paddr[2] == stweb_pkg::REG_WINDOW_SPAN);
    assign prdata     = w_span_sel ? r_window_span : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_span <= stweb_pkg::WINDOW_SPAN_RESET;
        end else if (psel && penable && pwrite && w_span_sel) begin
            r_window_span <= pwdata;
        end
    end

    stweb_mem #(
        .DEPTH (stweb_pkg::CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    stweb_walk u_walk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_window_span     (r_window_span),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_time_value      (i_time_value),
        .i_evt_type        (i_evt_type),
        .i_interface_id    (i_interface_id),
        .i_match_interface (i_match_interface),
        .i_event_tag       (i_event_tag),
        .i_max_found       (i_max_found),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_result          (w_result),
        .o_mem_we          (w_mem_we),
        .o_mem_waddr       (w_mem_waddr),
        .o_mem_wdata       (w_mem_wdata),
        .o_mem_re          (w_mem_re),
        .o_mem_raddr       (w_mem_raddr),
        .i_mem_rdata       (w_mem_rdata)
    );

    assign o_kind               = w_result.kind;
    assign o_number             = w_result.number;
    assign o_dropped_oldest     = w_result.dropped_oldest;
    assign o_slot               = w_result.slot;
    assign o_match_time         = w_result.match_time;
    assign o_match_type         = w_result.match_type;
    assign o_match_interface_id = w_result.match_interface_id;
    assign o_match_tag          = w_result.match_tag;
    assign o_occupancy          = w_result.occupancy;
    assign o_last               = w_result.last;

endmodule

// ----- design/stweb_mem.sv -----
module stweb_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  stweb_pkg::t_entry   i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output stweb_pkg::t_entry   o_rdata
);

    stweb_pkg::t_entry r_mem [DEPTH];
    stweb_pkg::t_entry r_rdata;

    // The read register only loads on a read, so a stalled walk keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/stweb_walk.sv -----
`include "sliding_time_window_event_buffer_assert.svh"

module stweb_walk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_window_span,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_mode,
    input  logic [31:0]           i_time_value,
    input  logic [31:0]           i_evt_type,
    input  logic [7:0]            i_interface_id,
    input  logic                  i_match_interface,
    input  logic [31:0]           i_event_tag,
    input  logic [4:0]            i_max_found,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output stweb_pkg::t_result    o_result,

    output logic                  o_mem_we,
    output logic [$clog2(stweb_pkg::CAPACITY)-1:0] o_mem_waddr,
    output stweb_pkg::t_entry     o_mem_wdata,
    output logic                  o_mem_re,
    output logic [$clog2(stweb_pkg::CAPACITY)-1:0] o_mem_raddr,
    input  stweb_pkg::t_entry     i_mem_rdata
);

    localparam int CAPACITY = stweb_pkg::CAPACITY;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int FW = (CW > 5) ? CW : 5;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL     = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPIRE,
        S_EXP_DONE,
        S_QUERY,
        S_Q_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_issued, n_issued;
    logic [CW-1:0]      r_found, n_found;
    logic [CW-1:0]      r_expired, n_expired;
    logic [31:0]        r_time, n_time;
    logic [31:0]        r_type, n_type;
    logic [7:0]         r_ifid, n_ifid;
    logic               r_use_if, n_use_if;
    logic [4:0]         r_maxf, n_maxf;
    logic               r_out_valid, n_out_valid;
    stweb_pkg::t_result r_out, n_out;

    logic w_out_free;
    logic w_in_acc;
    logic w_old;
    logic w_match;
    logic w_reach_max;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] idx);
        f_next = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Strictly older than the signed cutoff time - span, compared without a sign.
    assign w_old = (33'(i_mem_rdata.ev_time) + 33'(i_window_span)) < 33'(r_time);

    assign w_match = ((r_type == '0) || (i_mem_rdata.ev_type == r_type)) &&
                     (!r_use_if || (i_mem_rdata.ev_ifid == r_ifid));
    assign w_reach_max = (FW'(r_found) + FW'(w_match)) >= FW'(r_maxf);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_addr      = r_addr;
        n_issued    = r_issued;
        n_found     = r_found;
        n_expired   = r_expired;
        n_time      = r_time;
        n_type      = r_type;
        n_ifid      = r_ifid;
        n_use_if    = r_use_if;
        n_maxf      = r_maxf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_tail;
        o_mem_wdata = '{ev_time: i_time_value, ev_type: i_evt_type,
                        ev_ifid: i_interface_id, ev_tag: i_event_tag};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_time    = i_time_value;
                    n_type    = i_evt_type;
                    n_ifid    = i_interface_id;
                    n_use_if  = i_match_interface;
                    n_maxf    = i_max_found;
                    n_found   = '0;
                    n_expired = '0;
                    n_issued  = '0;
                    unique case (i_mode)
                        stweb_pkg::MODE_ADD: begin
                            o_mem_we    = 1'b1;
                            n_tail      = f_next(r_tail);
                            n_out_valid = 1'b1;
                            n_out       = '0;
                            n_out.kind  = stweb_pkg::KIND_ADD_DONE;
                            n_out.last  = 1'b1;
                            // A full ring overwrites its oldest entry at the tail.
                            if (r_count == FULL) begin
                                n_head               = f_next(r_head);
                                n_out.dropped_oldest = 1'b1;
                                n_out.occupancy      = 5'(r_count);
                            end else begin
                                n_count         = r_count + CW'(1);
                                n_out.occupancy = 5'(r_count + CW'(1));
                            end
                        end
                        stweb_pkg::MODE_EXPIRE: begin
                            if (r_count == '0) begin
                                n_out_valid     = 1'b1;
                                n_out           = '0;
                                n_out.kind      = stweb_pkg::KIND_EXPIRE_DONE;
                                n_out.occupancy = 5'(r_count);
                                n_out.last      = 1'b1;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = S_EXPIRE;
                            end
                        end
                        stweb_pkg::MODE_QUERY: begin
                            if ((r_count != '0) && (i_max_found != '0)) begin
                                o_mem_re = 1'b1;
                                n_addr   = r_head;
                                n_issued = CW'(1);
                                n_state  = S_QUERY;
                            end else begin
                                n_state = S_Q_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXPIRE: begin
                if (w_old) begin
                    n_head    = f_next(r_head);
                    n_count   = r_count - CW'(1);
                    n_expired = r_expired + CW'(1);
                    // Fetch the new head now so the next check runs next cycle.
                    if (r_count != CW'(1)) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_next(r_head);
                    end else begin
                        n_state = S_EXP_DONE;
                    end
                end else begin
                    n_state = S_EXP_DONE;
                end
            end
            S_EXP_DONE: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.kind      = stweb_pkg::KIND_EXPIRE_DONE;
                    n_out.number    = 5'(r_expired);
                    n_out.occupancy = 5'(r_count);
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_QUERY: begin
                // A match waits for the output register; the read data holds meanwhile.
                if (!w_match || w_out_free) begin
                    if (w_match) begin
                        n_out_valid              = 1'b1;
                        n_out                    = '0;
                        n_out.kind               = stweb_pkg::KIND_QUERY_MATCH;
                        n_out.slot               = 4'(r_addr);
                        n_out.match_time         = i_mem_rdata.ev_time;
                        n_out.match_type         = i_mem_rdata.ev_type;
                        n_out.match_interface_id = i_mem_rdata.ev_ifid;
                        n_out.match_tag          = i_mem_rdata.ev_tag;
                        n_out.occupancy          = 5'(r_count);
                        n_found                  = r_found + CW'(1);
                    end
                    if ((r_issued < r_count) && !w_reach_max) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = f_next(r_addr);
                        n_addr      = f_next(r_addr);
                        n_issued    = r_issued + CW'(1);
                    end else begin
                        n_state = S_Q_DONE;
                    end
                end
            end
            S_Q_DONE: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out           = '0;
                    n_out.kind      = stweb_pkg::KIND_QUERY_DONE;
                    n_out.number    = 5'(r_found);
                    n_out.occupancy = 5'(r_count);
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_issued    <= '0;
            r_found     <= '0;
            r_expired   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_found     <= n_found;
            r_expired   <= n_expired;
            r_out_valid <= n_out_valid;
        end
        r_addr   <= n_addr;
        r_time   <= n_time;
        r_type   <= n_type;
        r_ifid   <= n_ifid;
        r_use_if <= n_use_if;
        r_maxf   <= n_maxf;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `STWEB_ASSERT_ALWAYS(a_count_bound, r_count <= FULL, "held count above capacity")
    `STWEB_ASSERT_ALWAYS(a_tail_tracks_head,
        r_tail == AW'((32'(r_head) + 32'(r_count)) % CAPACITY), "tail out of step with head")
    `STWEB_ASSERT_IMPLY(a_no_rw_overlap, o_mem_we, !o_mem_re && (r_state == S_IDLE),
        "memory write during a walk")
    `STWEB_ASSERT_IMPLY(a_found_bound, r_state == S_Q_DONE, FW'(r_found) <= FW'(r_maxf),
        "query reported more matches than allowed")
    `STWEB_ASSERT_NEXT(a_exp_done_emits, (r_state == S_EXP_DONE) && w_out_free,
        r_out_valid && r_out.last && (r_out.kind == stweb_pkg::KIND_EXPIRE_DONE),
        "expire done result missing")

endmodule
